@@ hdl/dtm_pkg.sv @@
// ----------------------------------------------------------------------------
// Dither threshold matrix package
// Shared types, constants and helper functions for the threshold matrix
// generator: command and status structs, controller states and the layout.
// ----------------------------------------------------------------------------
`default_nettype none

package dtm_pkg;

  localparam int unsigned SlopeW   = 8;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned IndexW   = 6;
  // Only accumulator bits 11..4 reach the output, so 12 bits carry it exactly.
  localparam int unsigned AccW     = LevelW + 4;
  localparam int unsigned PixelW   = 4;
  localparam int unsigned PairW    = 2;

  localparam logic [LevelW-1:0] LevelBase = 8'd146;
  localparam logic [PixelW-1:0] LastPixel = 4'd15;
  localparam logic [PairW-1:0]  LastPair  = 2'd2;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } dtm_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
  } dtm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
  } dtm_status_t;

  // Ordered-dither layout: matrix offset of each of the 16 pixel positions.
  function automatic logic [IndexW-1:0] dither_offset(input logic [PixelW-1:0] pix);
    logic [IndexW-1:0] off;
    begin
      case (pix)
        4'd0:    off = 6'd0;
        4'd1:    off = 6'd30;
        4'd2:    off = 6'd24;
        4'd3:    off = 6'd6;
        4'd4:    off = 6'd15;
        4'd5:    off = 6'd45;
        4'd6:    off = 6'd39;
        4'd7:    off = 6'd21;
        4'd8:    off = 6'd12;
        4'd9:    off = 6'd42;
        4'd10:   off = 6'd36;
        4'd11:   off = 6'd18;
        4'd12:   off = 6'd3;
        4'd13:   off = 6'd33;
        4'd14:   off = 6'd27;
        default: off = 6'd9;
      endcase
      return off;
    end
  endfunction

  // Per-pixel increment of a pair: the signed difference of the upper level
  // (lower level plus slope, wrapped) and the lower level, extended to AccW.
  function automatic logic [AccW-1:0] pair_inc(input logic [LevelW-1:0] lo,
                                               input logic [SlopeW-1:0] slope);
    logic [LevelW-1:0] hi;
    logic [LevelW:0]   diff;
    begin
      hi   = lo + slope;
      diff = {1'b0, hi} - {1'b0, lo};
      return {{(AccW-LevelW-1){diff[LevelW]}}, diff};
    end
  endfunction

endpackage

`default_nettype wire

@@ hdl/dither_threshold_matrix_gen.sv @@
// ----------------------------------------------------------------------------
// Dither threshold matrix generator
// From one contrast slope byte, produces the 48 threshold bytes of a 4x4
// ordered-dither matrix with three interpolated grey ranges.
//
//   Channel   Ports                                       Handshake
//   -------   -----------------------------------------   ------------------
//   command   start, busy, slope_i                        start & !busy
//   result    valid_o, matrix_index_o, threshold_o,       valid_o strobe,
//             last_of_run_o                               one cycle each
//
// A command is taken while idle; its 48 results follow, one per cycle, with
// busy high throughout, so a new command is not taken until the run is over.
// The pixel and pair counters of the datapath, stepping one result per cycle,
// mark the end of the run. Reset returns the controller to idle and clears the
// counters. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module dither_threshold_matrix_gen (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire  [dtm_pkg::SlopeW-1:0]   slope_i,
  output logic                         valid_o,
  output logic [dtm_pkg::IndexW-1:0]   matrix_index_o,
  output logic [dtm_pkg::LevelW-1:0]   threshold_o,
  output logic                         last_of_run_o
);
  import dtm_pkg::*;

  dtm_cmd_t    cmd;
  dtm_status_t status;

  // Sequencer.
  dtm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .valid_o  (valid_o)
  );

  // Level and interpolation datapath.
  dtm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .slope_i        (slope_i),
    .status_o       (status),
    .matrix_index_o (matrix_index_o),
    .threshold_o    (threshold_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

`default_nettype wire

@@ hdl/dtm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Dither threshold matrix controller
// Two-state sequencer: waits for a start, then steps the datapath once per
// cycle until the datapath reports the final result of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module dtm_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start,
  input  dtm_pkg::dtm_status_t  status_i,
  output dtm_pkg::dtm_cmd_t     cmd_o,
  output logic                  busy,
  output logic                  valid_o
);
  import dtm_pkg::*;

  dtm_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    busy       = 1'b0;
    valid_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        busy       = 1'b1;
        valid_o    = 1'b1;
        cmd_o.step = 1'b1;
        if (status_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/dtm_datapath.sv @@
// ----------------------------------------------------------------------------
// Dither threshold matrix datapath
// Holds the slope, the current lower level, the interpolation accumulator and
// increment, and the pair and pixel counters; forms each result from them.
// ----------------------------------------------------------------------------
`default_nettype none

module dtm_datapath (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  dtm_pkg::dtm_cmd_t            cmd_i,
  input  wire  [dtm_pkg::SlopeW-1:0]   slope_i,
  output dtm_pkg::dtm_status_t         status_o,
  output logic [dtm_pkg::IndexW-1:0]   matrix_index_o,
  output logic [dtm_pkg::LevelW-1:0]   threshold_o,
  output logic                         last_of_run_o
);
  import dtm_pkg::*;

  logic [SlopeW-1:0] slope_q;
  logic [LevelW-1:0] lo_q, lo_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [AccW-1:0]   inc_q, inc_d;
  logic [PairW-1:0]  pair_q, pair_d;
  logic [PixelW-1:0] pix_q, pix_d;
  logic [LevelW-1:0] base_lvl;
  logic [LevelW-1:0] next_lo;
  logic              last;

  // Level 0 is the base minus half the slope; the next pair starts one slope up.
  assign base_lvl = LevelBase - {1'b0, slope_i[SlopeW-1:1]};
  assign next_lo  = lo_q + slope_q;
  assign last     = (pair_q == LastPair) && (pix_q == LastPixel);

  // Load, pixel step and pair change.
  always_comb begin
    lo_d   = lo_q;
    acc_d  = acc_q;
    inc_d  = inc_q;
    pair_d = pair_q;
    pix_d  = pix_q;
    if (cmd_i.load) begin
      lo_d   = base_lvl;
      acc_d  = {base_lvl, 4'd0};
      inc_d  = pair_inc(base_lvl, slope_i);
      pair_d = '0;
      pix_d  = '0;
    end else if (cmd_i.step) begin
      if (pix_q == LastPixel) begin
        lo_d   = next_lo;
        acc_d  = {next_lo, 4'd0};
        inc_d  = pair_inc(next_lo, slope_q);
        pair_d = pair_q + 1'b1;
        pix_d  = '0;
      end else begin
        acc_d = acc_q + inc_q;
        pix_d = pix_q + 1'b1;
      end
    end
  end

  // Counters are control state and get reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q <= '0;
      pix_q  <= '0;
    end else begin
      pair_q <= pair_d;
      pix_q  <= pix_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      slope_q <= slope_i;
    end
    lo_q  <= lo_d;
    acc_q <= acc_d;
    inc_q <= inc_d;
  end

  // Result fields of the current pixel.
  assign matrix_index_o = dither_offset(pix_q) + {{(IndexW-PairW){1'b0}}, pair_q};
  assign threshold_o    = acc_q[AccW-1:4];
  assign last_of_run_o  = last;
  assign status_o.last  = last;

endmodule

`default_nettype wire

@@ test/dither_threshold_matrix_gen_test.sv @@
// ----------------------------------------------------------------------------
// Dither threshold matrix generator testbench
// Sends contrast slope commands, directed ones first and then random ones,
// under three idle patterns of the sender. It predicts the 48 threshold
// transactions of every accepted slope and checks each result strobe, field by
// field, against the oldest prediction.
// ----------------------------------------------------------------------------

module dither_threshold_matrix_gen_test;

  timeunit 1ns;
  timeprecision 1ps;

  import dtm_pkg::*;

  localparam int unsigned ResultsPerSlope = 48;
  // This margin covers a full run.
  localparam int unsigned SettleCycles    = 64;
  localparam int unsigned CycleLimit      = 200000;
  localparam int unsigned ReportLimit     = 10;

  // Matrix offset of each of the 16 pixel positions of the ordered layout.
  localparam logic [IndexW-1:0] DitherLayout [16] = '{
    6'd0,  6'd30, 6'd24, 6'd6,
    6'd15, 6'd45, 6'd39, 6'd21,
    6'd12, 6'd42, 6'd36, 6'd18,
    6'd3,  6'd33, 6'd27, 6'd9
  };

  typedef struct packed {
    logic [IndexW-1:0] index;
    logic [LevelW-1:0] threshold;
    logic              last;
  } matrix_entry_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [SlopeW-1:0]  slope_i;
  logic               valid_o;
  logic [IndexW-1:0]  matrix_index_o;
  logic [LevelW-1:0]  threshold_o;
  logic               last_of_run_o;

  matrix_entry_t      threshold_q [$];
  int unsigned        error_count = 0;
  int unsigned        cycle_count = 0;
  int unsigned        idle_pct    = 0;

  dither_threshold_matrix_gen i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .slope_i        (slope_i),
    .valid_o        (valid_o),
    .matrix_index_o (matrix_index_o),
    .threshold_o    (threshold_o),
    .last_of_run_o  (last_of_run_o)
  );

  always #4 clk_i = ~clk_i;

  // Stop the run if the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Compute the 48 threshold transactions of one slope and queue them.
  function automatic void predict_matrix(input logic [SlopeW-1:0] slope);
    logic [LevelW-1:0] level [4];
    logic [15:0]       acc;
    logic [15:0]       pixel_inc;
    matrix_entry_t     entry;
    int                n;
    level[0] = LevelBase - {1'b0, slope[SlopeW-1:1]};
    for (int k = 1; k < 4; k++) begin
      level[k] = level[k-1] + slope;
    end
    n = 0;
    for (int k = 0; k < 3; k++) begin
      acc       = {4'b0, level[k], 4'b0};
      // A falling pair wraps here and the accumulator wraps with it.
      pixel_inc = {8'b0, level[k+1]} - {8'b0, level[k]};
      for (int p = 0; p < 16; p++) begin
        entry.index     = DitherLayout[p] + k[IndexW-1:0];
        entry.threshold = acc[11:4];
        entry.last      = (n == ResultsPerSlope - 1);
        threshold_q.push_back(entry);
        acc = acc + pixel_inc;
        n++;
      end
    end
  endfunction

  // Check every result strobe against the oldest prediction.
  always @(posedge clk_i) begin
    matrix_entry_t want;
    if (rst_ni && valid_o !== 1'b0) begin
      if (threshold_q.size() == 0) begin
        error_count <= error_count + 1;
        if (error_count < ReportLimit) begin
          $display("unexpected result: index %0d threshold %0d last %0b",
                   matrix_index_o, threshold_o, last_of_run_o);
        end
      end else begin
        want = threshold_q.pop_front();
        if (valid_o !== 1'b1 || matrix_index_o !== want.index ||
            threshold_o !== want.threshold || last_of_run_o !== want.last) begin
          error_count <= error_count + 1;
          if (error_count < ReportLimit) begin
            $display("mismatch: expected index %0d threshold %0d last %0b, got %0d %0d %0b",
                     want.index, want.threshold, want.last,
                     matrix_index_o, threshold_o, last_of_run_o);
          end
        end
      end
    end
  end

  // Offer one slope until the block takes it; noise is driven while start is low.
  task automatic send_slope(input logic [SlopeW-1:0] slope);
    logic go;
    logic done;
    done = 1'b0;
    while (!done) begin
      go = ($urandom_range(99) >= idle_pct);
      start   <= go;
      slope_i <= go ? slope : SlopeW'($urandom);
      @(posedge clk_i);
      if (go && !busy) begin
        predict_matrix(slope);
        done = 1'b1;
      end
    end
  endtask

  // Hold off the sender until every predicted transaction has arrived.
  task automatic wait_for_results();
    start <= 1'b0;
    while (threshold_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Mostly uniform slopes, with the edges of the range now and then.
  function automatic logic [SlopeW-1:0] pick_slope();
    logic [SlopeW-1:0] edges [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    if ($urandom_range(7) == 0) begin
      return edges[$urandom_range(5)];
    end
    return SlopeW'($urandom);
  endfunction

  // Field extremes, level wrap and falling pairs.
  task automatic test_directed();
    logic [SlopeW-1:0] slopes [14] = '{
      8'd0, 8'd255, 8'd1, 8'd254, 8'd127, 8'd128, 8'h55, 8'hAA,
      8'd200, 8'd91, 8'd92, 8'd170, 8'd2, 8'd64
    };
    idle_pct = 0;
    foreach (slopes[i]) begin
      send_slope(slopes[i]);
    end
  endtask

  // Random slopes with the given sender idle rate, and an occasional drain.
  task automatic test_random(input int unsigned count, input int unsigned pct);
    idle_pct = pct;
    repeat (count) begin
      send_slope(pick_slope());
      if ($urandom_range(39) == 0) begin
        wait_for_results();
      end
    end
  endtask

  // The sender waits for a full drain after each of a few slopes.
  task automatic test_drain_pause();
    idle_pct = 26;
    repeat (4) begin
      send_slope(pick_slope());
      wait_for_results();
    end
  endtask

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    slope_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(100, 26);
    test_random(100, 68);
    test_random(100, 0);
    test_drain_pause();

    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0 && threshold_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
